// ----- src/bbc_pkg.sv -----
// Package for the barcode bar counter.
// Holds widths, default parameter values, register and end-cause codes and shared structs.
// Used by every other file of the block but bbc_cell; depends on nothing.
`default_nettype none

package bbc_pkg;

  localparam int WINDOW_DEPTH_DEF  = 10;
  localparam int RAW_PER_POINT_DEF = 2;
  localparam int SAMPLE_BITS_DEF   = 10;

  localparam int THR_W      = 10;
  localparam int BARS_W     = 8;
  localparam int DIST_W     = 16;
  localparam int TICKS_W    = 4;
  localparam int CAUSE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0] DEFAULT_WHITE  = DIST_W'(200);
  localparam logic [THR_W-1:0]  THR_RESET      = THR_W'(40);
  localparam logic [BARS_W-1:0] BARS_MAX       = {BARS_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_MAX       = {DIST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_THRESHOLD = 2'd0,
    REG_TARGET_BARS    = 2'd1,
    REG_EXTRA_SPACING  = 2'd2
  } reg_index_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_TARGET = 2'd1,
    CAUSE_GAP    = 2'd2
  } end_cause_t;

  typedef struct packed {
    logic [THR_W-1:0]  edge_threshold;
    logic [BARS_W-1:0] target_bars;
    logic [DIST_W-1:0] extra_spacing;
  } cfg_t;

  typedef struct packed {
    logic [BARS_W-1:0] bar_count;
    logic              over_bar;
    logic              scan_running;
    end_cause_t        end_cause;
  } track_t;

endpackage

`default_nettype wire

// ----- src/bbc_in_if.sv -----
// Input channel of the barcode bar counter: valid, ready and one sample item.
// Depends on bbc_pkg for the default sample width and the tick width.
`default_nettype none

interface bbc_in_if import bbc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] line_sample;
  logic [TICKS_W-1:0]     wheel_ticks;
  logic                   start_scan;

  modport source (output valid, output line_sample, output wheel_ticks, output start_scan,
                  input ready);
  modport sink   (input valid, input line_sample, input wheel_ticks, input start_scan,
                  output ready);
endinterface

`default_nettype wire

// ----- src/bbc_out_if.sv -----
// Result channel of the barcode bar counter: valid, ready and one result item.
// Depends on bbc_pkg for field widths.
`default_nettype none

interface bbc_out_if import bbc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [BARS_W-1:0]         bar_count;
  logic                      over_bar;
  logic                      scan_running;
  logic [CAUSE_W-1:0]        end_cause;
  logic signed [SAMPLE_BITS:0] gradient;

  modport source (output valid, output bar_count, output over_bar, output scan_running,
                  output end_cause, output gradient, input ready);
  modport sink   (input valid, input bar_count, input over_bar, input scan_running,
                  input end_cause, input gradient, output ready);
endinterface

`default_nettype wire

// ----- src/bbc_cell.sv -----
// One cell of the point window: holds one averaged point and passes it on when the
// window advances. Depends on nothing but its width parameter.
`default_nettype none

module bbc_cell #(
  parameter int WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift_en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ----- src/bbc_tracker.sv -----
// Bar tracker: hysteresis edge machine, bar count, run distances and scan end.
// Depends on bbc_pkg for widths, codes and the cfg_t and track_t structs.
`default_nettype none

module bbc_tracker import bbc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        start_scan,
  input  logic [TICKS_W-1:0]          wheel_ticks,
  input  logic signed [SAMPLE_BITS:0] gradient,
  input  cfg_t                        cfg,
  output track_t                      status_next
);

  localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;

  logic              active, active_next;
  logic              bright_wait, bright_wait_next;
  logic [BARS_W-1:0] bars_seen, bars_seen_next;
  logic [DIST_W-1:0] run_distance, run_distance_next;
  logic [DIST_W-1:0] white_run, white_run_next;

  logic signed [CMP_W-1:0] grad_x;
  logic signed [CMP_W-1:0] thr_x;
  logic [DIST_W:0]         run_sum;
  logic [DIST_W:0]         gap_limit;
  logic [DIST_W-1:0]       spacing;
  logic                    act0;
  logic                    bw0;
  logic [BARS_W-1:0]       bars0;
  logic [DIST_W-1:0]       run0;
  logic [DIST_W-1:0]       white0;
  end_cause_t              cause;

  assign grad_x = CMP_W'(gradient);
  assign thr_x  = signed'({(CMP_W - THR_W)'(0), cfg.edge_threshold});
  assign spacing = (cfg.extra_spacing < DEFAULT_WHITE) ? DEFAULT_WHITE : cfg.extra_spacing;
  assign run_sum = {1'b0, run_distance} + (DIST_W + 1)'(wheel_ticks);

  always_comb begin
    act0   = start_scan | active;
    bw0    = start_scan ? 1'b0 : bright_wait;
    bars0  = start_scan ? '0 : bars_seen;
    white0 = start_scan ? DEFAULT_WHITE : white_run;
    if (start_scan) begin
      run0 = '0;
    end else if (active) begin
      run0 = run_sum[DIST_W] ? DIST_MAX : run_sum[DIST_W-1:0];
    end else begin
      run0 = run_distance;
    end
    gap_limit = {1'b0, white0} + {1'b0, spacing};

    active_next       = act0;
    bright_wait_next  = bw0;
    bars_seen_next    = bars0;
    run_distance_next = run0;
    white_run_next    = white0;
    cause             = CAUSE_NONE;

    if (act0) begin
      if (!bw0) begin
        if (grad_x < -thr_x) begin
          if (bars0 != '0) begin
            white_run_next = run0;
          end
          bars_seen_next    = (bars0 == BARS_MAX) ? bars0 : bars0 + BARS_W'(1);
          bright_wait_next  = 1'b1;
          run_distance_next = '0;
          if (cfg.target_bars != '0 && bars_seen_next >= cfg.target_bars) begin
            cause = CAUSE_TARGET;
          end
        end else if ({1'b0, run0} > gap_limit) begin
          cause = CAUSE_GAP;
        end
      end else if (grad_x > thr_x) begin
        bright_wait_next  = 1'b0;
        run_distance_next = '0;
      end
      if (cause != CAUSE_NONE) begin
        active_next      = 1'b0;
        bright_wait_next = 1'b0;
      end
    end

    status_next.bar_count    = bars_seen_next;
    status_next.over_bar     = bright_wait_next;
    status_next.scan_running = active_next;
    status_next.end_cause    = cause;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      bright_wait  <= 1'b0;
      bars_seen    <= '0;
      run_distance <= '0;
      white_run    <= DEFAULT_WHITE;
    end else if (accept) begin
      active       <= active_next;
      bright_wait  <= bright_wait_next;
      bars_seen    <= bars_seen_next;
      run_distance <= run_distance_next;
      white_run    <= white_run_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/barcode_bar_counter.sv -----
// Barcode bar counter top level: sample averaging, the chain of window cells,
// the bar tracker, the configuration registers and the result register.
// Depends on bbc_pkg, bbc_in_if, bbc_out_if, bbc_cell and bbc_tracker.
//
// Unless the output stalls, the block takes one sample item per clock cycle and returns
// one result item for each in the cycle after acceptance; the whole update is combinational.
// The result is held in an output register, and a new item is taken in the same cycle
// that the last result leaves; while a result waits unaccepted the input is held off.
// Every RAW_PER_POINT samples are averaged into a point that enters a
// chain of WINDOW_DEPTH cells; the gradient is the newest cell minus the oldest. There
// is no warm-up after reset: the window starts at zero and gradients are reported
// from the first item. Registers are written through cfg_we, cfg_index and cfg_data
// and should only be changed while no item is in flight.
`default_nettype none

module barcode_bar_counter import bbc_pkg::*; #(
  parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
  parameter int RAW_PER_POINT = RAW_PER_POINT_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bbc_in_if.sink                samples,
  bbc_out_if.source             results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(RAW_PER_POINT);
  localparam int REC_K = SUM_W + 3;
  localparam int REC_W = REC_K + 1;
  localparam int PROD_W = SUM_W + REC_W;
  localparam longint REC_VAL = ((64'sd1 <<< REC_K) + RAW_PER_POINT - 1) / RAW_PER_POINT;
  localparam logic [REC_W-1:0] REC_M = REC_W'(REC_VAL);
  localparam int PH_W = (RAW_PER_POINT > 1) ? $clog2(RAW_PER_POINT) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(RAW_PER_POINT - 1);

  cfg_t cfg;

  logic                   accept;
  logic [PH_W-1:0]        raw_phase;
  logic [SUM_W-1:0]       held_raw;
  logic [SUM_W-1:0]       sum_full;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] avg;
  logic                   pt_done;
  logic [SAMPLE_BITS-1:0] chain [0:WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] newest;
  logic [SAMPLE_BITS-1:0] oldest;
  logic signed [SAMPLE_BITS:0] grad_next;
  track_t                 status_next;

  assign accept = samples.valid && samples.ready;
  assign samples.ready = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_threshold <= THR_RESET;
      cfg.target_bars    <= '0;
      cfg.extra_spacing  <= DEFAULT_WHITE;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_EDGE_THRESHOLD: cfg.edge_threshold <= cfg_data[THR_W-1:0];
        REG_TARGET_BARS:    cfg.target_bars    <= cfg_data[BARS_W-1:0];
        REG_EXTRA_SPACING:  cfg.extra_spacing  <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The point average is a multiply by a rounded-up reciprocal, exact for every sum.
  assign sum_full = held_raw + SUM_W'(samples.line_sample);
  assign prod     = PROD_W'(sum_full) * PROD_W'(REC_M);
  assign avg      = prod[REC_K +: SAMPLE_BITS];
  assign pt_done  = (raw_phase == PH_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_phase <= '0;
      held_raw  <= '0;
    end else if (accept) begin
      if (pt_done) begin
        raw_phase <= '0;
        held_raw  <= '0;
      end else begin
        raw_phase <= raw_phase + PH_W'(1);
        held_raw  <= sum_full;
      end
    end
  end

  assign chain[0] = avg;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    bbc_cell #(
      .WIDTH (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (accept && pt_done),
      .d        (chain[i]),
      .q        (chain[i+1])
    );
  end

  assign newest    = pt_done ? avg : chain[1];
  assign oldest    = pt_done ? chain[WINDOW_DEPTH-1] : chain[WINDOW_DEPTH];
  assign grad_next = $signed({1'b0, newest}) - $signed({1'b0, oldest});

  bbc_tracker #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .start_scan  (samples.start_scan),
    .wheel_ticks (samples.wheel_ticks),
    .gradient    (grad_next),
    .cfg         (cfg),
    .status_next (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.bar_count    <= status_next.bar_count;
      results.over_bar     <= status_next.over_bar;
      results.scan_running <= status_next.scan_running;
      results.end_cause    <= status_next.end_cause;
      results.gradient     <= grad_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/barcode_bar_counter_tb.sv -----
`timescale 1ns / 100ps
// Testbench for barcode_bar_counter: drives sample items, predicts every result item
// and checks it. Depends on bbc_pkg, bbc_in_if, bbc_out_if and the block itself.

module barcode_bar_counter_tb import bbc_pkg::*;;

  localparam int GRAD_W       = SAMPLE_BITS_DEF + 1;
  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_STALL   = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ALT_BARS     = 16;
  localparam int MAX_SAMPLE   = (1 << SAMPLE_BITS_DEF) - 1;

  typedef struct packed {
    logic [SAMPLE_BITS_DEF-1:0] line_sample;
    logic [TICKS_W-1:0]         wheel_ticks;
    logic                       start_scan;
  } sample_item_t;

  typedef struct packed {
    logic [BARS_W-1:0] bar_count;
    logic              over_bar;
    logic              scan_running;
    end_cause_t        end_cause;
    logic [GRAD_W-1:0] gradient;
  } bar_report_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bbc_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) samples_ch ();
  bbc_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) results_ch ();

  barcode_bar_counter dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sample_item_t pending_samples[$];
  bar_report_t  expected_reports[$];

  int items_queued;
  int items_accepted;
  int random_items;
  int failures;
  int mismatches;
  int cycle_count;
  bit in_taken;

  int burst_left;
  int gap_left;

  int stall_left;
  int ready_mode;
  int mode_left;
  int long_stall_asks;
  int long_stall_served;

  // Predicted state of the bar tracker and its registers.
  int threshold_reg;
  int target_reg;
  int spacing_reg;
  int raw_sum;
  int raw_count;
  int points [WINDOW_DEPTH_DEF];
  int newest;
  bit awaiting_bright;
  int bars;
  int distance;
  int last_white;
  bit scanning;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic reset_tracker();
    threshold_reg = int'(THR_RESET);
    target_reg    = 0;
    spacing_reg   = int'(DEFAULT_WHITE);
    raw_sum       = 0;
    raw_count     = 0;
    foreach (points[i]) points[i] = 0;
    newest          = 0;
    awaiting_bright = 1'b0;
    bars            = 0;
    distance        = 0;
    last_white      = int'(DEFAULT_WHITE);
    scanning        = 1'b0;
  endtask

  task automatic predict_report(input sample_item_t it, output bar_report_t rep);
    int         grad;
    int         spacing;
    end_cause_t cause;
    cause = CAUSE_NONE;
    raw_sum += int'(it.line_sample);
    raw_count++;
    if (raw_count >= RAW_PER_POINT_DEF) begin
      newest = (newest + 1) % WINDOW_DEPTH_DEF;
      points[newest] = raw_sum / RAW_PER_POINT_DEF;
      raw_sum = 0;
      raw_count = 0;
    end
    grad = points[newest] - points[(newest + 1) % WINDOW_DEPTH_DEF];

    if (it.start_scan) begin
      scanning        = 1'b1;
      bars            = 0;
      distance        = 0;
      last_white      = int'(DEFAULT_WHITE);
      awaiting_bright = 1'b0;
    end else if (scanning) begin
      distance += int'(it.wheel_ticks);
      if (distance > int'(DIST_MAX)) distance = int'(DIST_MAX);
    end

    if (scanning) begin
      if (!awaiting_bright) begin
        spacing = (spacing_reg < int'(DEFAULT_WHITE)) ? int'(DEFAULT_WHITE) : spacing_reg;
        if (grad < -threshold_reg) begin
          if (bars >= 1) last_white = distance;
          if (bars < int'(BARS_MAX)) bars++;
          awaiting_bright = 1'b1;
          distance = 0;
          if (target_reg > 0 && bars >= target_reg) cause = CAUSE_TARGET;
        end else if (distance > last_white + spacing) begin
          cause = CAUSE_GAP;
        end
      end else if (grad > threshold_reg) begin
        awaiting_bright = 1'b0;
        distance = 0;
      end
      if (cause != CAUSE_NONE) begin
        scanning = 1'b0;
        awaiting_bright = 1'b0;
      end
    end

    rep.bar_count    = BARS_W'(bars);
    rep.over_bar     = awaiting_bright;
    rep.scan_running = scanning;
    rep.end_cause    = cause;
    rep.gradient     = GRAD_W'(grad);
  endtask

  task automatic report_mismatch(input bar_report_t want, input bar_report_t got);
    failures++;
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: expected count %0d over %0b run %0b cause %0d grad %0d",
               want.bar_count, want.over_bar, want.scan_running, want.end_cause,
               $signed(want.gradient));
      $display("          actual   count %0d over %0b run %0b cause %0d grad %0d",
               got.bar_count, got.over_bar, got.scan_running, got.end_cause,
               $signed(got.gradient));
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    sample_item_t next_item;
    if (rst) begin
      samples_ch.valid <= 1'b0;
    end else if (!samples_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        samples_ch.valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        next_item = pending_samples.pop_front();
        samples_ch.line_sample <= next_item.line_sample;
        samples_ch.wheel_ticks <= next_item.wheel_ticks;
        samples_ch.start_scan  <= next_item.start_scan;
        samples_ch.valid       <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        samples_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: a stall pattern that changes its mode now and then, plus long holds on request.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      results_ch.ready <= 1'b0;
    end else if (long_stall_asks > long_stall_served) begin
      long_stall_served++;
      stall_left = LONG_STALL - 1;
      results_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: results_ch.ready <= 1'b1;
        1: results_ch.ready <= 1'($urandom_range(0, 1));
        default: results_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: check each result item, then predict for each accepted sample item.
  always @(posedge clk) begin
    bar_report_t got;
    bar_report_t want;
    sample_item_t taken;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= samples_ch.valid && samples_ch.ready;
      if (results_ch.valid && results_ch.ready) begin
        got.bar_count    = results_ch.bar_count;
        got.over_bar     = results_ch.over_bar;
        got.scan_running = results_ch.scan_running;
        got.end_cause    = end_cause_t'(results_ch.end_cause);
        got.gradient     = results_ch.gradient;
        if (expected_reports.size() == 0) begin
          failures++;
          mismatches++;
          if (mismatches <= 10) $display("result item arrived with none expected");
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) report_mismatch(want, got);
        end
      end
      if (samples_ch.valid && samples_ch.ready) begin
        taken.line_sample = samples_ch.line_sample;
        taken.wheel_ticks = samples_ch.wheel_ticks;
        taken.start_scan  = samples_ch.start_scan;
        predict_report(taken, want);
        expected_reports.push_back(want);
        items_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [SAMPLE_BITS_DEF-1:0] clip_sample(input int v);
    if (v < 0) return '0;
    if (v > MAX_SAMPLE) return SAMPLE_BITS_DEF'(MAX_SAMPLE);
    return SAMPLE_BITS_DEF'(v);
  endfunction

  task automatic queue_item(input int sample, input int ticks, input bit start);
    sample_item_t it;
    it.line_sample = clip_sample(sample);
    it.wheel_ticks = TICKS_W'(ticks);
    it.start_scan  = start;
    pending_samples.push_back(it);
    items_queued++;
  endtask

  // A run of samples around one level, now and then broken by a fully random item.
  task automatic queue_run(input int level, input int len, input bit start_first);
    for (int k = 0; k < len; k++) begin
      if (k != 0 && $urandom_range(0, 24) == 0)
        queue_item($urandom_range(0, MAX_SAMPLE), $urandom_range(0, 15),
                   $urandom_range(0, 15) == 0);
      else
        queue_item(level + $urandom_range(0, 80) - 40, $urandom_range(0, 15),
                   start_first && k == 0);
    end
    random_items += len;
  endtask

  task automatic queue_scan();
    int segments;
    int white_len;
    segments = $urandom_range(1, 8);
    queue_run($urandom_range(550, MAX_SAMPLE), $urandom_range(1, 12), 1'b1);
    for (int s = 0; s < segments && random_items < RANDOM_ITEMS; s++) begin
      white_len = ($urandom_range(0, 5) == 0) ? $urandom_range(35, 90) : $urandom_range(2, 24);
      queue_run($urandom_range(550, MAX_SAMPLE), white_len, 1'b0);
      queue_run($urandom_range(0, 350), $urandom_range(2, 24), 1'b0);
    end
  endtask

  task automatic write_register(input reg_index_t idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_EDGE_THRESHOLD: threshold_reg = value & ((1 << THR_W) - 1);
      REG_TARGET_BARS:    target_reg    = value & ((1 << BARS_W) - 1);
      REG_EXTRA_SPACING:  spacing_reg   = value & ((1 << DIST_W) - 1);
      default: ;
    endcase
  endtask

  task automatic write_settings(input int thr, input int target, input int spacing);
    write_register(REG_EDGE_THRESHOLD, thr);
    write_register(REG_TARGET_BARS, target);
    write_register(REG_EXTRA_SPACING, spacing);
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int phase;
    int thr;
    int target;
    int spacing;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_EDGE_THRESHOLD;
    cfg_data = '0;
    samples_ch.valid = 1'b0;
    samples_ch.line_sample = '0;
    samples_ch.wheel_ticks = '0;
    samples_ch.start_scan = 1'b0;
    results_ch.ready = 1'b0;
    reset_tracker();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extremes of the sample and tick fields, idle items, a scan and a restart mid-scan.
    repeat (4) queue_item(MAX_SAMPLE, 0, 1'b0);
    queue_item(MAX_SAMPLE, 15, 1'b1);
    repeat (3) queue_item(MAX_SAMPLE, 15, 1'b0);
    repeat (6) queue_item(0, 15, 1'b0);
    repeat (6) queue_item(MAX_SAMPLE, 0, 1'b0);
    queue_item(0, 15, 1'b1);
    repeat (3) queue_item(0, 7, 1'b0);
    wait_drained();

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: write_settings(0, 1, 0);
        1: write_settings((1 << THR_W) - 1, int'(BARS_MAX), int'(DIST_MAX));
        default: begin
          thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << THR_W) - 1)
                                            : $urandom_range(20, 300);
          case ($urandom_range(0, 3))
            0: target = 0;
            1: target = int'(BARS_MAX);
            default: target = $urandom_range(1, 6);
          endcase
          case ($urandom_range(0, 3))
            0: spacing = int'(DIST_MAX);
            1: spacing = $urandom_range(0, 199);
            default: spacing = $urandom_range(150, 600);
          endcase
          write_settings(thr, target, spacing);
        end
      endcase
      repeat ($urandom_range(1, 3)) begin
        if (random_items < RANDOM_ITEMS) queue_scan();
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(10, 30))
          queue_item($urandom_range(0, MAX_SAMPLE), $urandom_range(0, 15),
                     $urandom_range(0, 7) == 0);
      end
      if (phase == 0) long_stall_asks++;
      wait_drained();
      phase++;
    end

    // Points alternating between the extremes with a zero threshold give a bar every four
    // items.
    write_settings(0, 0, int'(DIST_MAX));
    if (raw_count != 0) queue_item(MAX_SAMPLE, 0, 1'b0);
    queue_item(0, $urandom_range(0, 15), 1'b1);
    queue_item(0, $urandom_range(0, 15), 1'b0);
    repeat (2) queue_item(MAX_SAMPLE, $urandom_range(0, 15), 1'b0);
    for (int b = 0; b < ALT_BARS; b++) begin
      repeat (2) queue_item(0, $urandom_range(0, 15), 1'b0);
      repeat (2) queue_item(MAX_SAMPLE, $urandom_range(0, 15), 1'b0);
    end
    wait_drained();

    repeat (4) @(posedge clk);
    if (failures == 0 && expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
